// ===== hdl/pts_pkg.sv =====
// ----------------------------------------------------------------------------
// pts_pkg
// Shared constants and types of the prime test and search block.
// ----------------------------------------------------------------------------
`default_nettype none
package pts_pkg;
  localparam int unsigned MapBits = 32768;
  localparam logic [31:0] TopPrime = 32'd4294967291;
  localparam logic [31:0] SmallestPrime = 32'd2;
  localparam int unsigned DivBits = 17;

  localparam logic [1:0] CmdTest = 2'd0;
  localparam logic [1:0] CmdBelow = 2'd1;
  localparam logic [1:0] CmdAbove = 2'd2;

  typedef struct packed {
    logic done;
    logic rem_zero;
  } div_stat_t;
endpackage
`default_nettype wire

// ===== hdl/pts_div.sv =====
// ----------------------------------------------------------------------------
// pts_div
// Shared restoring remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module pts_div
  import pts_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [31:0]         dividend_i,
  input  wire logic [DivBits-1:0]  divisor_i,
  output div_stat_t                stat_o
);
  logic [31:0]        num_q, num_d;
  logic [DivBits-1:0] den_q, den_d;
  logic [DivBits:0]   rem_q, rem_d;
  logic [5:0]         cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivBits:0]   shifted;

  always_comb begin
    num_d = num_q;
    den_d = den_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    shifted = {rem_q[DivBits-1:0], num_q[31]};
    if (start_i) begin
      num_d = dividend_i;
      den_d = divisor_i;
      rem_d = '0;
      cnt_d = 6'd32;
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[30:0], 1'b0};
      rem_d = (shifted >= {1'b0, den_q}) ? shifted - {1'b0, den_q} : shifted;
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign stat_o.done = done_q;
  assign stat_o.rem_zero = (rem_q == '0);
endmodule
`default_nettype wire

// ===== hdl/prime_test_and_search_top.sv =====
// ----------------------------------------------------------------------------
// prime_test_and_search_top
// Prime test, highest prime at or below and lowest prime at or above a value.
// ----------------------------------------------------------------------------
// channel   dir  fields (tdata, low bit up)
// s_axis    in   cmd[1:0], value[33:2]
// m_axis    out  is_prime[0], found_prime[32:1]
//
// Each odd candidate is trial divided by odd divisors from 3 while p*p <= n.
// Each divisor is one pass of the shared remainder unit; a search repeats
// the test on each odd candidate across the gap.
// Trivial cases skip the divider and go straight to the done state. No pass runs after reset.
// A result waits in the output register; the next word is taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none
module prime_test_and_search_top
  import pts_pkg::*;
#(
  parameter int unsigned MAP_BITS = MapBits
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // cmd, value
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata   // is_prime, found_prime
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHK  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_DONE = 3'd3;
  localparam logic [DivBits-1:0] FirstDiv = DivBits'(3);
  localparam logic [DivBits+16:0] FirstSq = (DivBits+17)'(9);
  localparam logic [31:0] MapLimit = 32'(2 * MAP_BITS - 1);

  logic [2:0]            state_q, state_d;
  logic [1:0]            cmd_q, cmd_d;
  logic [31:0]           n_q, n_d;
  logic [DivBits-1:0]    p_q, p_d;
  logic [DivBits+16:0]   psq_q, psq_d;
  logic                  flag_q, flag_d;
  logic [31:0]           found_q, found_d;
  logic                  ov_q, ov_d;
  logic                  div_start;
  div_stat_t             div_stat;
  logic [1:0]            in_cmd;
  logic [31:0]           in_val;

  assign in_cmd = s_axis_tdata[1:0];
  assign in_val = s_axis_tdata[33:2];
  assign s_axis_tready = (state_q == S_IDLE);

  pts_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (n_q),
    .divisor_i  (p_q),
    .stat_o     (div_stat)
  );

  always_comb begin
    state_d = state_q;
    cmd_d = cmd_q;
    n_d = n_q;
    p_d = p_q;
    psq_d = psq_q;
    flag_d = flag_q;
    found_d = found_q;
    ov_d = ov_q;
    div_start = 1'b0;
    if (m_axis_tready) ov_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_d = in_cmd;
          flag_d = 1'b0;
          found_d = '0;
          p_d = FirstDiv;
          psq_d = FirstSq;
          state_d = S_DONE;
          case (in_cmd)
            CmdTest: begin
              if (in_val >= SmallestPrime && in_val <= TopPrime) begin
                if (!in_val[0]) flag_d = (in_val == SmallestPrime);
                else begin
                  n_d = in_val;
                  state_d = S_CHK;
                end
              end
            end
            CmdBelow: begin
              if (in_val >= TopPrime) found_d = TopPrime;
              else if (in_val == SmallestPrime) found_d = SmallestPrime;
              else if (in_val > SmallestPrime) begin
                n_d = (in_val - 32'd1) | 32'd1;
                state_d = S_CHK;
              end
            end
            CmdAbove: begin
              if (in_val <= SmallestPrime) found_d = SmallestPrime;
              else if (in_val <= TopPrime) begin
                n_d = in_val | 32'd1;
                if (n_d >= TopPrime) found_d = TopPrime;
                else state_d = S_CHK;
              end
            end
            default: ;
          endcase
        end
      end
      S_CHK: begin
        if (psq_q > {(DivBits-15)'(0), n_q} || {15'd0, p_q} > MapLimit) begin
          if (cmd_q == CmdTest) flag_d = 1'b1;
          else found_d = n_q;
          state_d = S_DONE;
        end else begin
          div_start = 1'b1;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_d = S_CHK;
          if (div_stat.rem_zero) begin
            p_d = FirstDiv;
            psq_d = FirstSq;
            case (cmd_q)
              CmdBelow: begin
                n_d = n_q - 32'd2;
                if (n_d < 32'd3) begin
                  found_d = SmallestPrime;
                  state_d = S_DONE;
                end
              end
              CmdAbove: begin
                n_d = n_q + 32'd2;
                if (n_d >= TopPrime) begin
                  found_d = TopPrime;
                  state_d = S_DONE;
                end
              end
              default: state_d = S_DONE;
            endcase
          end else begin
            p_d = p_q + DivBits'(2);
            psq_d = psq_q + {15'd0, p_q, 2'b00} + (DivBits+17)'(4);
          end
        end
      end
      S_DONE: begin
        if (!ov_q || m_axis_tready) begin
          ov_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    n_q <= n_d;
    p_q <= p_d;
    psq_q <= psq_d;
    flag_q <= flag_d;
    found_q <= found_d;
  end

  logic flag_out_q;
  logic [31:0] found_out_q;
  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && (!ov_q || m_axis_tready)) begin
      flag_out_q <= flag_q;
      found_out_q <= found_q;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata = {7'd0, found_out_q, flag_out_q};

  a_one_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[32:1] != '0))
    else $error("both result fields set");
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> state_q == S_DIV)
    else $error("remainder done outside divide state");
  a_odd_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> p_q[0] && n_q[0])
    else $error("even divisor or candidate");
  a_start_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> state_q == S_DIV)
    else $error("divide started without entering divide state");
endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks prime test, highest prime at or below and lowest prime at or above.
// Directed corner words, then random words that are mostly small values.
// Every result is compared against a trial division predictor.
// Both sides idle at random, and the sender drains the block once mid-run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module testbench
  import pts_pkg::*;
;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] value;
    logic        drain;
  } word_t;

  typedef struct packed {
    logic        is_prime;
    logic [31:0] found_prime;
  } answer_t;

  localparam logic [1:0] CmdNone = 2'd3;
  localparam int unsigned CycleLimit = 10000000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;  // cmd[1:0], value[33:2], zero[39:34]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;  // is_prime[0], found_prime[32:1], zero[39:33]

  word_t   pend_words[$];
  answer_t expected_results[$];
  int unsigned errors;
  int unsigned cycles;
  int unsigned sent_words;
  int unsigned got_words;
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned stall_left;
  logic        stall_mode;

  prime_test_and_search_top dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic logic prime_by_division(logic [31:0] n);
    longint unsigned d;
    if (n < SmallestPrime || n > TopPrime) return 1'b0;
    if (n[0] == 1'b0) return n == SmallestPrime;
    for (d = 3; d * d <= n; d += 2) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [31:0] prime_at_or_below(logic [31:0] v);
    logic [31:0] n;
    if (v < SmallestPrime) return 32'd0;
    if (v >= TopPrime) return TopPrime;
    if (v == SmallestPrime) return SmallestPrime;
    for (n = (v - 32'd1) | 32'd1; n >= 32'd3; n -= 32'd2) begin
      if (prime_by_division(n)) return n;
    end
    return SmallestPrime;
  endfunction

  function automatic logic [31:0] prime_at_or_above(logic [31:0] v);
    logic [31:0] n;
    if (v > TopPrime) return 32'd0;
    if (v <= SmallestPrime) return SmallestPrime;
    for (n = v | 32'd1; n < TopPrime; n += 32'd2) begin
      if (prime_by_division(n)) return n;
    end
    return TopPrime;
  endfunction

  function automatic answer_t predict_answer(logic [1:0] cmd, logic [31:0] value);
    answer_t a;
    a = '0;
    case (cmd)
      CmdTest:  a.is_prime = prime_by_division(value);
      CmdBelow: a.found_prime = prime_at_or_below(value);
      CmdAbove: a.found_prime = prime_at_or_above(value);
      default:  a = '0;
    endcase
    return a;
  endfunction

  task automatic add_word(logic [1:0] cmd, logic [31:0] value, logic drain = 1'b0);
    word_t w;
    w.cmd = cmd;
    w.value = value;
    w.drain = drain;
    pend_words.push_back(w);
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      burst_left <= 0;
      gap_left <= 0;
      sent_words <= 0;
    end else begin
      logic busy;
      busy = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(predict_answer(s_axis_tdata[1:0], s_axis_tdata[33:2]));
        sent_words <= sent_words + 1;
        busy = 1'b0;
      end
      if (!busy) begin
        if (gap_left != 0) begin
          s_axis_tvalid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pend_words.size() != 0 &&
                     !(pend_words[0].drain &&
                       (expected_results.size() != 0 || m_axis_tvalid))) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {6'd0, pend_words[0].value, pend_words[0].cmd};
          void'(pend_words.pop_front());
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 8);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left <= 0;
      stall_mode <= 1'b0;
      got_words <= 0;
      errors <= 0;
    end else begin
      answer_t want;
      if (m_axis_tvalid && m_axis_tready) begin
        got_words <= got_words + 1;
        if (expected_results.size() == 0) begin
          $error("unexpected word: tdata=%h", m_axis_tdata);
          errors <= errors + 1;
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tdata[0] !== want.is_prime) begin
            $error("is_prime: expected %0d, actual %0d", want.is_prime, m_axis_tdata[0]);
            errors <= errors + 1;
          end
          if (m_axis_tdata[32:1] !== want.found_prime) begin
            $error("found_prime: expected %0d, actual %0d",
                   want.found_prime, m_axis_tdata[32:1]);
            errors <= errors + 1;
          end
        end
      end
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 1);
        stall_left <= $urandom_range(5, 60);
        m_axis_tready <= 1'b1;
      end else begin
        stall_left <= stall_left - 1;
        m_axis_tready <= stall_mode ? ($urandom_range(0, 2) == 0) : 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    logic [31:0] r;
    logic [1:0]  c;
    int unsigned i;
    rst_ni = 1'b0;

    add_word(CmdTest, 32'd0);
    add_word(CmdTest, 32'd1);
    add_word(CmdTest, 32'd2);
    add_word(CmdTest, 32'd3);
    add_word(CmdTest, 32'd4);
    add_word(CmdTest, 32'd65521);
    add_word(CmdTest, 32'd65535);
    add_word(CmdTest, 32'd65537);
    add_word(CmdTest, 32'hFFFF_FFFE);
    add_word(CmdTest, 32'd4294967289);
    add_word(CmdTest, 32'd4294967292);
    add_word(CmdTest, 32'hFFFF_FFFF);
    add_word(CmdBelow, 32'd0);
    add_word(CmdBelow, 32'd1);
    add_word(CmdBelow, 32'd2);
    add_word(CmdBelow, 32'd3);
    add_word(CmdBelow, 32'd100);
    add_word(CmdBelow, TopPrime);
    add_word(CmdBelow, 32'hFFFF_FFFF);
    add_word(CmdAbove, 32'd0);
    add_word(CmdAbove, 32'd2);
    add_word(CmdAbove, 32'd4);
    add_word(CmdAbove, 32'd65520);
    add_word(CmdAbove, 32'd4294967292);
    add_word(CmdAbove, 32'hFFFF_FFFF);
    add_word(CmdNone, 32'hFFFF_FFFF);

    for (i = 0; i < 114; i++) begin
      c = $urandom_range(0, 15) == 0 ? CmdNone : 2'($urandom_range(0, 2));
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: r = $urandom_range(0, 65535);
        5, 6:          r = $urandom_range(0, 262143);
        7:             r = $urandom_range(0, 64);
        8: begin
          // big value with a tiny factor, or at or above the top prime
          r = $urandom;
          if (c == CmdTest) r = r - (r % 15);
          else r = TopPrime + $urandom_range(0, 4);
        end
        default:       r = $urandom_range(65500, 66000);
      endcase
      add_word(c, r, i == 57);
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pend_words.size() == 0 && !s_axis_tvalid);
    wait (expected_results.size() == 0);
    repeat (200) @(posedge clk_i);
    $display("covered %0d words in, %0d words out, test and both searches, edge values",
             sent_words, got_words);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
